// ===== rtl/ftm_pkg.sv =====
// ----------------------------------------------------------------------------
// ftm_pkg
// Shared types for the fraction reducer: divider request and status words.
// ----------------------------------------------------------------------------
`default_nettype none

package ftm_pkg;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ftm_divider.sv =====
// ----------------------------------------------------------------------------
// ftm_divider
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ftm_divider #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ftm_pkg::div_ctrl_t    ctrl_i,
  input  wire logic [DATA_WIDTH-1:0] dividend_i,
  input  wire logic [DATA_WIDTH-1:0] divisor_i,
  output ftm_pkg::div_stat_t         stat_o,
  output logic      [DATA_WIDTH-1:0] quotient_o,
  output logic      [DATA_WIDTH-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] q_q, q_d, dvs_q, dvs_d;
  logic [DATA_WIDTH:0]   r_q, r_d, trial;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  run_q, run_d, done_q, done_d;

  always_comb begin
    trial = {r_q[DATA_WIDTH-1:0], q_q[DATA_WIDTH-1]} - {1'b0, dvs_q};
    q_d = q_q;
    r_d = r_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      q_d = dividend_i;
      r_d = '0;
      dvs_d = divisor_i;
      cnt_d = CntW'(DATA_WIDTH);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial[DATA_WIDTH]) begin
        r_d = {r_q[DATA_WIDTH-1:0], q_q[DATA_WIDTH-1]};
        q_d = {q_q[DATA_WIDTH-2:0], 1'b0};
      end else begin
        r_d = trial;
        q_d = {q_q[DATA_WIDTH-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.done = done_q;
  assign quotient_o = q_q;
  assign remainder_o = r_q[DATA_WIDTH-1:0];

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("done while running");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (cnt_q != '0)) else $error("running with empty count");

endmodule

`default_nettype wire

// ===== rtl/fraction_to_mixed_number.sv =====
// ----------------------------------------------------------------------------
// fraction_to_mixed_number
// Reduces a fraction by its gcd and splits it into whole part and remainder.
// ----------------------------------------------------------------------------
// Steps: Euclid divisions until a zero remainder, then three more divisions
// (numerator and denominator by the gcd, then the split); a zero
// denominator strobes the next cycle. One word at a time: busy stays high
// until the result strobe. All divisions share one bit-serial divider.
// Reset clears the controller; the receiver cannot stall.
`default_nettype none

module fraction_to_mixed_number #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [DATA_WIDTH-1:0] numerator_i,
  input  wire logic [DATA_WIDTH-1:0] denominator_i,
  output logic                       valid_o,
  output logic      [DATA_WIDTH-1:0] whole_part_o,
  output logic      [DATA_WIDTH-1:0] remainder_numerator_o,
  output logic      [DATA_WIDTH-1:0] reduced_denominator_o,
  output logic      [DATA_WIDTH-1:0] common_factor_o,
  output logic                       invalid_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_GCD, S_DIVN, S_DIVD, S_SPLIT
  } state_e;

  state_e state_q;
  logic [DATA_WIDTH-1:0] num_q, den_q, x_q, y_q, rn_q, rd_q;
  logic [DATA_WIDTH-1:0] dividend, divisor, quo, rem;
  ftm_pkg::div_ctrl_t dctl;
  ftm_pkg::div_stat_t dst;
  logic go_q;

  assign busy = (state_q != S_IDLE);
  assign dctl.start = go_q;

  always_comb begin
    unique case (state_q)
      S_DIVN:  begin dividend = num_q; divisor = x_q; end
      S_DIVD:  begin dividend = den_q; divisor = x_q; end
      S_SPLIT: begin dividend = rn_q;  divisor = rd_q; end
      default: begin dividend = x_q;   divisor = y_q; end
    endcase
  end

  ftm_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk_i, .rst_ni, .ctrl_i(dctl), .dividend_i(dividend), .divisor_i(divisor),
    .stat_o(dst), .quotient_o(quo), .remainder_o(rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      go_q <= 1'b0;
      valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) begin
          num_q <= numerator_i;
          den_q <= denominator_i;
          x_q <= numerator_i;
          y_q <= denominator_i;
          if (denominator_i == '0) begin
            valid_o <= 1'b1;
            invalid_o <= 1'b1;
            whole_part_o <= '0;
            remainder_numerator_o <= '0;
            reduced_denominator_o <= '0;
            common_factor_o <= '0;
          end else begin
            state_q <= S_GCD;
            go_q <= 1'b1;
          end
        end
        S_GCD: if (dst.done) begin
          x_q <= y_q;
          y_q <= rem;
          go_q <= 1'b1;
          if (rem == '0) begin
            x_q <= y_q;
            state_q <= S_DIVN;
          end
        end
        S_DIVN: if (dst.done) begin
          rn_q <= quo;
          state_q <= S_DIVD;
          go_q <= 1'b1;
        end
        S_DIVD: if (dst.done) begin
          rd_q <= quo;
          state_q <= S_SPLIT;
          go_q <= 1'b1;
        end
        S_SPLIT: if (dst.done) begin
          state_q <= S_IDLE;
          valid_o <= 1'b1;
          invalid_o <= 1'b0;
          whole_part_o <= quo;
          remainder_numerator_o <= rem;
          reduced_denominator_o <= rd_q;
          common_factor_o <= x_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVN) |-> (x_q != '0)) else $error("zero gcd");
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("strobe while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && denominator_i != '0) |=> busy) else $error("not busy");

endmodule

`default_nettype wire
